>>> src/swfs_pkg.sv
// swfs_pkg: shared types and constants of the single wire frame sender
// no dependencies
package swfs_pkg;

  localparam int FRAME_DATA_W = 8;
  localparam int FRAME_BITS_W = 4;
  localparam int STATUS_W     = 2;
  localparam int CFG_REG_W    = 16;
  localparam int CFG_IDX_W    = 3;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_SAMPLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NACK_WAIT   = 3'd4;

  // config reset values
  localparam logic [CFG_REG_W-1:0] RST_SHORT_LOW   = 16'd6;
  localparam logic [CFG_REG_W-1:0] RST_LONG_LOW    = 16'd60;
  localparam logic [CFG_REG_W-1:0] RST_ACK_TIMEOUT = 16'd300;
  localparam logic [CFG_REG_W-1:0] RST_ACK_SAMPLE  = 16'd24;
  localparam logic [CFG_REG_W-1:0] RST_NACK_WAIT   = 16'd42;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ACK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NACK   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ACK = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LOW    = 6'b000010,
    PH_HIGH   = 6'b000100,
    PH_WAIT   = 6'b001000,
    PH_SAMPLE = 6'b010000,
    PH_NACK   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [CFG_REG_W-1:0] short_low_ticks;
    logic [CFG_REG_W-1:0] long_low_ticks;
    logic [CFG_REG_W-1:0] ack_timeout_ticks;
    logic [CFG_REG_W-1:0] ack_sample_ticks;
    logic [CFG_REG_W-1:0] nack_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic                    start_req;
    logic [FRAME_DATA_W-1:0] frame_data;
    logic [FRAME_BITS_W-1:0] frame_bits;
    logic                    line_in;
  } item_t;

  typedef struct packed {
    logic                line_out;
    logic                line_enable;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

>>> src/swfs_in_reg.sv
// swfs_in_reg: input register stage holding one word for the tick core
// depends on swfs_pkg
module swfs_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  swfs_pkg::item_t in_item,
  input  logic          take,
  output logic          valid_r,
  output swfs_pkg::item_t item_r
);
  import swfs_pkg::*;

  logic valid_nxt;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> src/swfs_tick_core.sv
// swfs_tick_core: frame state, bit timing counter and one-tick step logic
// depends on swfs_pkg
module swfs_tick_core #(
  parameter int MAX_FRAME_BITS = 8,
  parameter int COUNTER_WIDTH  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  swfs_pkg::cfg_t  cfg,
  input  swfs_pkg::item_t item,
  input  logic           step,
  output swfs_pkg::res_t  res
);
  import swfs_pkg::*;

  localparam int SB_W = MAX_FRAME_BITS + 2;
  localparam int BL_W = $clog2(MAX_FRAME_BITS + 3);
  localparam int DX_W = MAX_FRAME_BITS + FRAME_DATA_W;

  phase_t                   phase_r, phase_nxt;
  logic [SB_W-1:0]          shift_r, shift_nxt;
  logic [BL_W-1:0]          bits_left_r, bits_left_nxt;
  logic [COUNTER_WIDTH-1:0] tick_r, tick_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic                     done;

  // zero acts as one, then cut to the counter width
  function automatic logic [COUNTER_WIDTH-1:0] load_len(input logic [CFG_REG_W-1:0] v);
    logic [31:0] w;
    w = (v == '0) ? 32'd1 : 32'(v);
    return w[COUNTER_WIDTH-1:0];
  endfunction

  function automatic logic bit_at(input logic [SB_W-1:0] sb, input logic [BL_W-1:0] bl);
    logic b;
    b = 1'b0;
    for (int i = 0; i < SB_W; i++) begin
      if (bl == BL_W'(i + 1)) begin
        b = sb[i];
      end
    end
    return b;
  endfunction

  function automatic logic [COUNTER_WIDTH-1:0] low_len(input logic b, input cfg_t c);
    return load_len(b ? c.short_low_ticks : c.long_low_ticks);
  endfunction

  function automatic logic [COUNTER_WIDTH-1:0] high_len(input logic b, input cfg_t c);
    return load_len(b ? c.long_low_ticks : c.short_low_ticks);
  endfunction

  // frame load terms
  int                       nb;
  logic [DX_W-1:0]          data_ext;
  logic [MAX_FRAME_BITS-1:0] payload;
  logic                     parity;
  logic [SB_W-1:0]          frame_sb;
  logic [BL_W-1:0]          frame_bl;

  always_comb begin
    if (item.frame_bits == '0) begin
      nb = 1;
    end else if (int'(item.frame_bits) > MAX_FRAME_BITS) begin
      nb = MAX_FRAME_BITS;
    end else begin
      nb = int'(item.frame_bits);
    end
    data_ext = DX_W'(item.frame_data);
    for (int i = 0; i < MAX_FRAME_BITS; i++) begin
      payload[i] = (i < nb) ? data_ext[i] : 1'b0;
    end
    parity   = ^payload;
    frame_sb = {1'b0, payload, parity};
    frame_bl = BL_W'(nb + 2);
  end

  logic [COUNTER_WIDTH-1:0] tick_dec, tick_inc;
  logic [BL_W-1:0]          bl_dec;
  logic [CFG_REG_W-1:0]     timeout_eff;

  assign tick_dec    = tick_r - 1'b1;
  assign tick_inc    = tick_r + 1'b1;
  assign bl_dec      = (bits_left_r != '0) ? bits_left_r - 1'b1 : bits_left_r;
  assign timeout_eff = (cfg.ack_timeout_ticks == '0) ? CFG_REG_W'(1) : cfg.ack_timeout_ticks;

  always_comb begin
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    tick_nxt      = tick_r;
    status_nxt    = status_r;
    done          = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (item.start_req) begin
          shift_nxt     = frame_sb;
          bits_left_nxt = frame_bl;
          phase_nxt     = PH_LOW;
          tick_nxt      = low_len(bit_at(frame_sb, frame_bl), cfg);
        end
      end
      PH_LOW: begin
        tick_nxt = tick_dec;
        if (tick_dec == '0) begin
          phase_nxt = PH_HIGH;
          tick_nxt  = high_len(bit_at(shift_r, bits_left_r), cfg);
        end
      end
      PH_HIGH: begin
        tick_nxt = tick_dec;
        if (tick_dec == '0) begin
          bits_left_nxt = bl_dec;
          if (bl_dec != '0) begin
            phase_nxt = PH_LOW;
            tick_nxt  = low_len(bit_at(shift_r, bl_dec), cfg);
          end else begin
            phase_nxt = PH_WAIT;
            tick_nxt  = '0;
          end
        end
      end
      PH_WAIT: begin
        if (!item.line_in) begin
          phase_nxt = PH_SAMPLE;
          tick_nxt  = load_len(cfg.ack_sample_ticks);
        end else if (32'(tick_inc) >= 32'(timeout_eff)) begin
          phase_nxt  = PH_IDLE;
          tick_nxt   = '0;
          status_nxt = ST_NO_ACK;
          done       = 1'b1;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_SAMPLE: begin
        tick_nxt = tick_dec;
        if (tick_dec == '0) begin
          if (item.line_in) begin
            phase_nxt  = PH_IDLE;
            status_nxt = ST_ACK;
            done       = 1'b1;
          end else begin
            phase_nxt = PH_NACK;
            tick_nxt  = load_len(cfg.nack_wait_ticks);
          end
        end
      end
      PH_NACK: begin
        tick_nxt = tick_dec;
        if (tick_dec == '0) begin
          phase_nxt  = PH_IDLE;
          status_nxt = ST_NACK;
          done       = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    res.done_res = done;
    res.status   = status_nxt;
    unique case (phase_nxt)
      PH_LOW: begin
        res.line_out = 1'b0; res.line_enable = 1'b1; res.busy_res = 1'b1;
      end
      PH_HIGH: begin
        res.line_out = 1'b1; res.line_enable = 1'b1; res.busy_res = 1'b1;
      end
      PH_WAIT, PH_SAMPLE, PH_NACK: begin
        res.line_out = 1'b1; res.line_enable = 1'b0; res.busy_res = 1'b1;
      end
      default: begin
        res.line_out = 1'b1; res.line_enable = 1'b1; res.busy_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      shift_r     <= '0;
      bits_left_r <= '0;
      tick_r      <= '0;
      status_r    <= ST_ACK;
    end else if (step) begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      tick_r      <= tick_nxt;
      status_r    <= status_nxt;
    end
  end

endmodule

>>> src/single_wire_frame_sender_unit.sv
// single_wire_frame_sender_unit: top level, config registers and result register
// depends on swfs_pkg, swfs_in_reg, swfs_tick_core
//
// Each input word is one tick of the wire timing: a start request, the frame
// payload and length, and the sampled wire level. From idle, a start sends a
// zero start bit, the payload MSB first and an even parity bit; a one bit is a
// short low phase then a long high phase, a zero bit the reverse. The wire is
// then released and the block polls for the low ack edge (no ack status after
// ack_timeout_ticks), samples the line ack_sample_ticks later (high ack, low
// nack plus nack_wait_ticks) and drives the wire high again, giving the status
// with done_res for one word. Every input word yields exactly one result word.
// Throughput is one word per cycle unless results stall; each word passes the
// input register, then the result register, with the whole tick update done
// by the logic between them. Config writes take effect at the next edge
// whatever the block is doing, so make them only while no word is in flight.
module single_wire_frame_sender_unit #(
  parameter int MAX_FRAME_BITS = 8,
  parameter int COUNTER_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config port
  input  logic                              cfg_we,
  input  logic [swfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swfs_pkg::CFG_REG_W-1:0]    cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_start_req,
  input  logic [swfs_pkg::FRAME_DATA_W-1:0] in_frame_data,
  input  logic [swfs_pkg::FRAME_BITS_W-1:0] in_frame_bits,
  input  logic                              in_line_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_line_out,
  output logic                              out_line_enable,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [swfs_pkg::STATUS_W-1:0]     out_status
);
  import swfs_pkg::*;

  cfg_t  cfg_r;
  item_t in_item, item_r;
  res_t  step_res, res_r;
  logic  item_valid_r;
  logic  out_valid_r, out_valid_nxt;
  logic  fire;

  // config registers, write only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_low_ticks   <= RST_SHORT_LOW;
      cfg_r.long_low_ticks    <= RST_LONG_LOW;
      cfg_r.ack_timeout_ticks <= RST_ACK_TIMEOUT;
      cfg_r.ack_sample_ticks  <= RST_ACK_SAMPLE;
      cfg_r.nack_wait_ticks   <= RST_NACK_WAIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_LOW:   cfg_r.short_low_ticks   <= cfg_wdata;
        REG_LONG_LOW:    cfg_r.long_low_ticks    <= cfg_wdata;
        REG_ACK_TIMEOUT: cfg_r.ack_timeout_ticks <= cfg_wdata;
        REG_ACK_SAMPLE:  cfg_r.ack_sample_ticks  <= cfg_wdata;
        REG_NACK_WAIT:   cfg_r.nack_wait_ticks   <= cfg_wdata;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  assign in_item.start_req  = in_start_req;
  assign in_item.frame_data = in_frame_data;
  assign in_item.frame_bits = in_frame_bits;
  assign in_item.line_in    = in_line_in;

  // a held word steps the core when the result register is free or draining
  assign fire = item_valid_r && (!out_valid_r || out_ready);

  swfs_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (fire),
    .valid_r  (item_valid_r),
    .item_r   (item_r)
  );

  swfs_tick_core #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS),
    .COUNTER_WIDTH  (COUNTER_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (item_r),
    .step  (fire),
    .res   (step_res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_out    = res_r.line_out;
  assign out_line_enable = res_r.line_enable;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_status      = res_r.status;

  // a finishing word always shows the wire back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> !res_r.busy_res && res_r.line_enable)
    else $error("done word while still busy");

  // the wire is released or driven low only inside a frame
  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (!res_r.line_enable || !res_r.line_out) |-> res_r.busy_res)
    else $error("wire not idle outside a frame");

  // a held input word is not lost while the core stalls
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !fire |=> item_valid_r && $stable(item_r))
    else $error("held input word dropped");

  // a stalled result word is not overwritten
  a_hold_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(res_r))
    else $error("stalled result word changed");

endmodule
